FILE: rtl/core/lcab_pkg.sv
// lcab_pkg: shared codes, widths and defaults for the life board unit.
// Holds the life rule used by the row update lanes.
// No dependencies.
`default_nettype none

package lcab_pkg;

  localparam int IDX_W      = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int ACT_W      = 2;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  typedef logic [3:0] nbr_count_t;

  function automatic logic life_next(input logic alive, input nbr_count_t n);
    logic res;
    if (alive) begin
      res = (n == 4'd2) || (n == 4'd3);
    end else begin
      res = (n == 4'd3);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcab_row_update.sv
// lcab_row_update: next generation of one board row, one lane per column.
// Rows above and below arrive already cleared when outside the board.
// Depends on lcab_pkg.
`default_nettype none

module lcab_row_update #(
  parameter int MAX_COLS = lcab_pkg::DEF_MAX_COLS
) (
  input  wire logic [MAX_COLS-1:0] above,
  input  wire logic [MAX_COLS-1:0] mid,
  input  wire logic [MAX_COLS-1:0] below,
  input  wire logic [MAX_COLS-1:0] col_mask,
  input  wire logic                row_live,
  output logic      [MAX_COLS-1:0] new_row
);

  logic [MAX_COLS-1:0] a_m, m_m, b_m;
  logic [MAX_COLS-1:0] a_l, a_r, m_l, m_r, b_l, b_r;
  lcab_pkg::nbr_count_t cnt;

  assign a_m = above & col_mask;
  assign m_m = mid   & col_mask;
  assign b_m = below & col_mask;

  // x_l[c] is column c-1, x_r[c] is column c+1
  assign a_l = a_m << 1;
  assign a_r = a_m >> 1;
  assign m_l = m_m << 1;
  assign m_r = m_m >> 1;
  assign b_l = b_m << 1;
  assign b_r = b_m >> 1;

  always_comb begin
    cnt = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(a_l[c]) + 4'(a_m[c]) + 4'(a_r[c]) + 4'(m_l[c]) + 4'(m_r[c])
          + 4'(b_l[c]) + 4'(b_m[c]) + 4'(b_r[c]);
      if (row_live && col_mask[c]) begin
        new_row[c] = lcab_pkg::life_next(mid[c], cnt);
      end else begin
        new_row[c] = mid[c];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/life_cellular_automaton_board_unit.sv
// life_cellular_automaton_board_unit: Game of Life board held as row words
// in one double-banked synchronous memory. Depends on lcab_pkg and lcab_row_update.
//
//   port group | direction | carries
//   in_*       | in        | action, row_index, col_index, cell_in (valid/stall)
//   out_*      | out       | cell_out, status (valid/stall)
//   cfg_*      | in        | row_count (index 0), col_count (index 1)
//
// Read, write and unused actions: a memory read, then the result, with the
// modified row word written back for a write on the board.
// Step: one row word per cycle through the memory port, then the result.
// After reset a clearing pass zeroes every row word of bank 0; in_stall is
// high meanwhile. A waiting result holds the block in its final state.
`default_nettype none

module life_cellular_automaton_board_unit #(
  parameter int MAX_ROWS = lcab_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lcab_pkg::DEF_MAX_COLS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lcab_pkg::ACT_W-1:0]      in_action,
  input  wire logic [lcab_pkg::IDX_W-1:0]      in_row_index,
  input  wire logic [lcab_pkg::IDX_W-1:0]      in_col_index,
  input  wire logic                            in_cell_in,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_cell_out,
  output logic                                 out_status,

  input  wire logic                            cfg_wr_en,
  input  wire logic [lcab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcab_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int KW    = $clog2(MAX_ROWS + 2);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CELL  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic                           bank_r, bank_nxt;
  logic [lcab_pkg::CFG_W-1:0]     row_count_r, col_count_r;

  logic [lcab_pkg::ACT_W-1:0]     act_r;
  logic [lcab_pkg::IDX_W-1:0]     row_r, col_r;
  logic                           val_r, oob_r;
  logic [MAX_COLS-1:0]            above_r, above_nxt, mid_r, mid_nxt;
  logic [MAX_COLS-1:0]            rd_data_r;

  logic                           out_valid_r, out_cell_r, out_status_r;

  logic [MAX_COLS-1:0]            mem_q [DEPTH];
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr, rd_addr;
  logic [MAX_COLS-1:0]            wr_data, cell_row;

  logic                           in_oob, out_free, produce, prod_cell, prod_status;
  logic                           vis_mid, vis_below;
  logic [MAX_COLS-1:0]            col_mask, below, new_row;

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_cell_out = out_cell_r;
  assign out_status   = out_status_r;
  assign out_free     = !out_valid_r || !out_stall;

  assign in_oob = (int'(in_row_index) >= MAX_ROWS) || (int'(in_row_index) >= int'(row_count_r))
               || (int'(in_col_index) >= MAX_COLS) || (int'(in_col_index) >= int'(col_count_r));

  // window: mid_r is row k-2, rd_data_r is row k-1
  assign vis_mid   = (int'(k_r) >= 2) && ((int'(k_r) - 2) < int'(row_count_r));
  assign vis_below = (int'(k_r) >= 1) && ((int'(k_r) - 1) < int'(row_count_r))
                  && ((int'(k_r) - 1) < MAX_ROWS);
  assign below     = vis_below ? rd_data_r : '0;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(col_count_r));
    end
  end

  lcab_row_update #(
    .MAX_COLS (MAX_COLS)
  ) u_row_update (
    .above    (above_r),
    .mid      (mid_r),
    .below    (below),
    .col_mask (col_mask),
    .row_live (vis_mid),
    .new_row  (new_row)
  );

  always_comb begin
    cell_row                = rd_data_r;
    cell_row[CW'(col_r)]    = val_r;
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    bank_nxt    = bank_r;
    above_nxt   = above_r;
    mid_nxt     = mid_r;
    produce     = 1'b0;
    prod_cell   = 1'b0;
    prod_status = lcab_pkg::STATUS_DONE;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_addr     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {1'b0, RW'(k_r)};
        k_nxt   = k_r + 1'b1;
        if (k_r == KW'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = {bank_r, RW'(in_row_index)};
        if (in_valid) begin
          k_nxt     = '0;
          state_nxt = (in_action == lcab_pkg::ACT_STEP) ? ST_STEP : ST_CELL;
        end
      end
      ST_CELL: begin
        rd_addr = {bank_r, RW'(row_r)};
        if (out_free) begin
          produce = 1'b1;
          if ((act_r == lcab_pkg::ACT_WRITE) || (act_r == lcab_pkg::ACT_READ)) begin
            prod_status = oob_r ? lcab_pkg::STATUS_OUTSIDE : lcab_pkg::STATUS_DONE;
          end
          prod_cell = (act_r == lcab_pkg::ACT_READ) && !oob_r && rd_data_r[CW'(col_r)];
          wr_en     = (act_r == lcab_pkg::ACT_WRITE) && !oob_r;
          wr_addr   = {bank_r, RW'(row_r)};
          wr_data   = cell_row;
          state_nxt = ST_IDLE;
        end
      end
      ST_STEP: begin
        rd_addr   = (int'(k_r) < MAX_ROWS) ? {bank_r, RW'(k_r)} : {bank_r, RW'(0)};
        wr_en     = (int'(k_r) >= 2);
        wr_addr   = {~bank_r, RW'(k_r - KW'(2))};
        wr_data   = new_row;
        above_nxt = vis_mid ? mid_r : '0;
        mid_nxt   = rd_data_r;
        k_nxt     = k_r + 1'b1;
        if (k_r == KW'(MAX_ROWS + 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          produce   = 1'b1;
          bank_nxt  = ~bank_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_q[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      k_r         <= '0;
      bank_r      <= 1'b0;
      row_count_r <= lcab_pkg::COUNT_RESET;
      col_count_r <= lcab_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      bank_r  <= bank_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          lcab_pkg::CFG_ROW_COUNT: row_count_r <= cfg_wdata;
          lcab_pkg::CFG_COL_COUNT: col_count_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    above_r <= above_nxt;
    mid_r   <= mid_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      act_r <= in_action;
      row_r <= in_row_index;
      col_r <= in_col_index;
      val_r <= in_cell_in;
      oob_r <= in_oob;
    end
    if (produce) begin
      out_cell_r   <= prod_cell;
      out_status_r <= prod_status;
    end
  end

  // a step only ever writes the bank that is not being read
  a_step_other_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && wr_en) |-> (wr_addr[AW-1] != bank_r && rd_addr[AW-1] == bank_r))
    else $error("step writes the live bank");

  // cell writes go to the live bank and only for coordinates on the board
  a_cell_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL && wr_en) |-> (wr_addr[AW-1] == bank_r && !oob_r))
    else $error("bad cell write");

  // the bank flips only when a step hands over its result
  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(bank_r)) |-> ($past(state_r == ST_DONE) && out_valid_r))
    else $error("bank flipped outside step completion");

  // no result appears during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !produce)
    else $error("result during clear");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for life_cellular_automaton_board_unit. Items are driven from a
// queue, each is predicted against a board kept here, and every result is checked in order.
// Depends on lcab_pkg and the board unit RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [lcab_pkg::ACT_W-1:0]     act_t;
  typedef logic [lcab_pkg::IDX_W-1:0]     idx_t;
  typedef logic [lcab_pkg::CFG_W-1:0]     cfg_word_t;
  typedef logic [lcab_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  localparam int MODEL_ROWS = lcab_pkg::DEF_MAX_ROWS;
  localparam int MODEL_COLS = lcab_pkg::DEF_MAX_COLS;
  localparam act_t ACT_UNUSED = 2'd3;
  localparam int IDLE_PCT = 18;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = MODEL_ROWS + 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    act_t action;
    idx_t row;
    idx_t col;
    logic alive;
  } board_item_t;

  typedef struct packed {
    logic cell_out;
    logic status;
  } board_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  act_t              in_action = lcab_pkg::ACT_WRITE;
  idx_t              in_row_index = '0;
  idx_t              in_col_index = '0;
  logic              in_cell_in = 1'b0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_cell_out;
  logic              out_status;

  logic              cfg_wr_en = 1'b0;
  cfg_idx_t          cfg_index = lcab_pkg::CFG_ROW_COUNT;
  cfg_word_t         cfg_wdata = '0;

  board_item_t   pending_items[$];
  board_result_t board_expect_q[$];
  board_item_t   offered_item;

  bit        life_board [MODEL_ROWS][MODEL_COLS];
  cfg_word_t rows_in_use = lcab_pkg::COUNT_RESET;
  cfg_word_t cols_in_use = lcab_pkg::COUNT_RESET;

  int  items_accepted = 0;
  int  results_checked = 0;
  int  steps_predicted = 0;
  int  flagged_predicted = 0;
  int  sizes_used = 1;
  int  failures = 0;
  logic calm;
  logic board_hold_req = 1'b0;
  logic hold_done = 1'b0;
  int  hold_left = 0;

  life_cellular_automaton_board_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_cell_in   (in_cell_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cell_out (out_cell_out),
    .out_status   (out_status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  // no random idling on either side for a while
  assign calm = (items_accepted >= 500) && (items_accepted < 700);

  function automatic board_result_t predict_board_item(board_item_t it);
    board_result_t res;
    bit next_gen [MODEL_ROWS][MODEL_COLS];
    int act_rows, act_cols, r, c, dr, dc, n;
    res.cell_out = 1'b0;
    res.status   = lcab_pkg::STATUS_DONE;
    act_rows = (int'(rows_in_use) > MODEL_ROWS) ? MODEL_ROWS : int'(rows_in_use);
    act_cols = (int'(cols_in_use) > MODEL_COLS) ? MODEL_COLS : int'(cols_in_use);
    case (it.action)
      lcab_pkg::ACT_WRITE, lcab_pkg::ACT_READ: begin
        if (int'(it.row) >= act_rows || int'(it.col) >= act_cols) begin
          res.status = lcab_pkg::STATUS_OUTSIDE;
          flagged_predicted++;
        end else if (it.action == lcab_pkg::ACT_WRITE) begin
          life_board[it.row][it.col] = it.alive;
        end else begin
          res.cell_out = life_board[it.row][it.col];
        end
      end
      lcab_pkg::ACT_STEP: begin
        // cells beyond the active area are carried over untouched
        next_gen = life_board;
        for (r = 0; r < act_rows; r++) begin
          for (c = 0; c < act_cols; c++) begin
            n = 0;
            for (dr = -1; dr <= 1; dr++) begin
              for (dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < act_rows &&
                    c + dc >= 0 && c + dc < act_cols) begin
                  n += int'(life_board[r + dr][c + dc]);
                end
              end
            end
            next_gen[r][c] = life_board[r][c] ? (n == 2 || n == 3) : (n == 3);
          end
        end
        life_board = next_gen;
        steps_predicted++;
      end
      default: ;
    endcase
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        board_expect_q = {board_expect_q, predict_board_item(offered_item)};
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered_item = pending_items.pop_front();
          in_valid     <= 1'b1;
          in_action    <= offered_item.action;
          in_row_index <= offered_item.row;
          in_col_index <= offered_item.col;
          in_cell_in   <= offered_item.alive;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (board_hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    board_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (board_expect_q.size() == 0) begin
        $error("result with no item outstanding: cell_out %0d status %0d",
               out_cell_out, out_status);
        failures++;
      end else begin
        exp_res = board_expect_q.pop_front();
        if (out_cell_out !== exp_res.cell_out) begin
          $error("cell_out mismatch: expected %0d, actual %0d", exp_res.cell_out, out_cell_out);
          failures++;
        end
        if (out_status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, out_status);
          failures++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_item(act_t action, int row, int col, logic alive);
    board_item_t it;
    it.action = action;
    it.row    = idx_t'(row);
    it.col    = idx_t'(col);
    it.alive  = alive;
    pending_items = {pending_items, it};
  endtask

  task automatic await_drain();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_valid || board_expect_q.size() != 0);
  endtask

  task automatic program_board_size(int rows, int cols);
    await_drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= lcab_pkg::CFG_ROW_COUNT;
    cfg_wdata <= cfg_word_t'(rows);
    @(posedge clk);
    cfg_index <= lcab_pkg::CFG_COL_COUNT;
    cfg_wdata <= cfg_word_t'(cols);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    rows_in_use = cfg_word_t'(rows);
    cols_in_use = cfg_word_t'(cols);
    sizes_used++;
  endtask

  task automatic queue_random_items(int count);
    board_item_t it;
    int act_rows, act_cols, pick, k;
    act_rows = (int'(rows_in_use) > MODEL_ROWS) ? MODEL_ROWS : int'(rows_in_use);
    act_cols = (int'(cols_in_use) > MODEL_COLS) ? MODEL_COLS : int'(cols_in_use);
    for (k = 0; k < count; k++) begin
      pick      = $urandom_range(0, 99);
      it.action = (pick < 50) ? lcab_pkg::ACT_WRITE : lcab_pkg::ACT_READ;
      it.row    = idx_t'($urandom_range(0, MODEL_ROWS - 1));
      it.col    = idx_t'($urandom_range(0, MODEL_COLS - 1));
      it.alive  = ($urandom_range(0, 99) < 45);
      if (pick < 78) begin
        if (act_rows != 0 && act_cols != 0) begin
          it.row = idx_t'($urandom_range(0, act_rows - 1));
          it.col = idx_t'($urandom_range(0, act_cols - 1));
        end
      end else if (pick < 88) begin
        it.action = lcab_pkg::ACT_STEP;
      end else if (pick < 95) begin
        if (act_rows < MODEL_ROWS && (act_cols == MODEL_COLS || $urandom_range(0, 1))) begin
          it.row = idx_t'($urandom_range(act_rows, MODEL_ROWS - 1));
        end else if (act_cols < MODEL_COLS) begin
          it.col = idx_t'($urandom_range(act_cols, MODEL_COLS - 1));
        end
      end else begin
        it.action = act_t'($urandom_range(lcab_pkg::ACT_WRITE, ACT_UNUSED));
      end
      pending_items = {pending_items, it};
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset board, corners, unused code, blinkers against the top and right edges
    queue_item(lcab_pkg::ACT_READ, 0, 0, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 63, 63, 1'b0);
    queue_item(lcab_pkg::ACT_WRITE, 0, 0, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 63, 63, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 0, 63, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 63, 0, 1'b1);
    queue_item(lcab_pkg::ACT_READ, 0, 63, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 63, 0, 1'b0);
    queue_item(ACT_UNUSED, 63, 63, 1'b1);
    queue_item(lcab_pkg::ACT_STEP, 0, 0, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 0, 0, 1'b0);
    queue_item(lcab_pkg::ACT_WRITE, 0, 30, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 0, 31, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 0, 32, 1'b1);
    queue_item(lcab_pkg::ACT_STEP, 0, 0, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 1, 31, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 63, 31, 1'b0);
    queue_item(lcab_pkg::ACT_WRITE, 10, 63, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 11, 63, 1'b1);
    queue_item(lcab_pkg::ACT_WRITE, 12, 63, 1'b1);
    queue_item(lcab_pkg::ACT_STEP, 0, 0, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 11, 62, 1'b0);
    queue_item(lcab_pkg::ACT_READ, 11, 0, 1'b0);
    queue_item(lcab_pkg::ACT_WRITE, 11, 63, 1'b0);
    queue_random_items(150);

    program_board_size(8, 8);
    queue_item(lcab_pkg::ACT_READ, 8, 0, 1'b0);
    queue_item(lcab_pkg::ACT_WRITE, 0, 8, 1'b1);
    queue_random_items(200);
    program_board_size(1, 1);
    queue_random_items(40);
    program_board_size(3, 3);
    queue_random_items(80);
    program_board_size(0, 5);
    queue_random_items(30);
    program_board_size(6, 0);
    queue_random_items(20);
    program_board_size(127, 127);
    queue_random_items(120);
    program_board_size(64, 1);
    queue_random_items(60);
    program_board_size(1, 64);
    queue_random_items(60);
    program_board_size(5, 7);
    queue_random_items(200);
    board_hold_req = 1'b1;
    program_board_size(100, 12);
    queue_random_items(120);
    program_board_size(12, 64);
    queue_random_items(150);

    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Checked %0d results over %0d board sizes: %0d generation steps, %0d flagged",
             results_checked, sizes_used, steps_predicted, flagged_predicted);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lcab_pkg.sv
rtl/core/lcab_row_update.sv
rtl/core/life_cellular_automaton_board_unit.sv
verif/tb_top.sv
